// ----- design/msss_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// msss_pkg
// Shared types and constants of the minimum statistics spectral subtraction
// core.
// ---------------------------------------------------------------------------
package msss_pkg;

	localparam int BINS          = 512;
	localparam int WINDOW_FRAMES = 8;
	localparam int IDX_W         = $clog2(BINS);
	localparam int SLOT_W        = (WINDOW_FRAMES > 1) ? $clog2(WINDOW_FRAMES) : 1;
	localparam int FILL_W        = $clog2(WINDOW_FRAMES + 1);
	localparam int HIST_DEPTH    = BINS * WINDOW_FRAMES;
	localparam int PW_W          = 48;
	localparam int GAIN_W        = 17;
	localparam int QUO_W         = 16;

	localparam logic [GAIN_W-1:0] UNITY = 17'd65536;
	localparam logic [PW_W-1:0]   PW_MAX = {PW_W{1'b1}};

	// register indexes of the configuration port
	localparam logic [1:0] CFG_ALPHA = 2'd0;
	localparam logic [1:0] CFG_BIAS  = 2'd1;
	localparam logic [1:0] CFG_FLOOR = 2'd2;

	localparam logic [15:0]       ALPHA_RST = 16'd62259;
	localparam logic [15:0]       BIAS_RST  = 16'd6144;
	localparam logic [GAIN_W-1:0] FLOOR_RST = 17'd6554;

	typedef struct packed {
		logic [8:0]         bin_index;
		logic signed [23:0] bin_real;
		logic signed [23:0] bin_imag;
		logic               frame_end;
	} in_beat_t;

	typedef struct packed {
		logic signed [23:0] out_real;
		logic signed [23:0] out_imag;
		logic [16:0]        applied_gain;
	} out_beat_t;

	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;

	typedef enum logic [4:0] {
		ST_CLR, ST_IDLE, ST_PW0, ST_PW1, ST_SM0, ST_SM1, ST_SM2, ST_SM3, ST_SM4,
		ST_MIN, ST_NZ0, ST_NZ1, ST_NZ2, ST_DIV, ST_SC0, ST_SC1, ST_SC2, ST_DONE
	} state_t;

endpackage
`default_nettype wire

// ----- design/min_statistics_spectral_subtraction_core.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// min_statistics_spectral_subtraction_core
// Per-bin noise suppressor: smoothed power, minimum over a history ring,
// spectral gain with floor.
// ---------------------------------------------------------------------------
// After reset the core sweeps the 512-entry smoothed power memory to zero;
// no bin is accepted during the sweep (configuration writes are taken).
// Bins are then handled one at a time by a sequencer around a shared
// 24x24 multiplier and two memories: the minimum is taken over one to 8
// history frames, and the gain needs the bit-serial divider only when the
// noise is below the power. A finished result sits in an output register,
// so the next bin is accepted while it waits.
module min_statistics_spectral_subtraction_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire msss_pkg::in_beat_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output msss_pkg::out_beat_t      out_data,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_addr,
	input  wire logic [16:0]         cfg_wdata
);
	import msss_pkg::*;

	state_t state_q, state_d;

	logic [15:0]       alpha_q;
	logic [15:0]       bias_q;
	logic [GAIN_W-1:0] floor_q;
	logic [GAIN_W-1:0] floorv;

	logic [IDX_W-1:0]  clr_q;
	logic [IDX_W-1:0]  idx_q;
	logic [23:0]       mre_q, mim_q;
	logic              nre_q, nim_q, last_q;
	logic [PW_W-1:0]   pw_q, old_q, sa_q, mn_q;
	logic [65:0]       acc_q;
	logic [GAIN_W-1:0] gain_q;
	logic [23:0]       ore_q, oim_q;
	logic [SLOT_W-1:0] slot_q;
	logic [FILL_W-1:0] filled_q, span, j_q;
	logic              pend_q;
	out_beat_t         out_q;
	logic              out_valid_q;

	logic [23:0]       mul_a, mul_b;
	logic [47:0]       mul_p;
	logic [GAIN_W-1:0] ua;
	logic [50:0]       ssum;
	logic [PW_W-1:0]   snew, nsat;
	logic [23:0]       scl, sres;
	logic              accept, out_load, j_go, use_floor;
	logic [GAIN_W-1:0] gdiv;

	logic              sp_we;
	logic [IDX_W-1:0]  sp_waddr;
	logic [PW_W-1:0]   sp_wdata, sp_rdata, hist_rdata;
	logic              hist_we;

	div_ctl_t          dctl_in, dctl_out;
	logic [QUO_W-1:0]  quo;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign floorv   = (floor_q > UNITY) ? UNITY : floor_q;
	assign ua       = UNITY - {1'b0, alpha_q};
	assign span     = (filled_q >= FILL_W'(WINDOW_FRAMES)) ? FILL_W'(WINDOW_FRAMES)
		: filled_q + 1'b1;
	assign j_go     = j_q < span;

	// shared multiplier
	always_comb begin
		case (state_q)
			ST_PW0:  begin mul_a = mre_q;                mul_b = mre_q;           end
			ST_PW1:  begin mul_a = mim_q;                mul_b = mim_q;           end
			ST_SM0:  begin mul_a = {8'b0, alpha_q};      mul_b = old_q[23:0];     end
			ST_SM1:  begin mul_a = {8'b0, alpha_q};      mul_b = old_q[47:24];    end
			ST_SM2:  begin mul_a = {7'b0, ua};           mul_b = pw_q[23:0];      end
			ST_SM3:  begin mul_a = {7'b0, ua};           mul_b = pw_q[47:24];     end
			ST_NZ0:  begin mul_a = {8'b0, bias_q};       mul_b = mn_q[23:0];      end
			ST_NZ1:  begin mul_a = {8'b0, bias_q};       mul_b = mn_q[47:24];     end
			ST_SC0:  begin mul_a = mre_q;                mul_b = {7'b0, gain_q};  end
			ST_SC1:  begin mul_a = mim_q;                mul_b = {7'b0, gain_q};  end
			default: begin mul_a = '0;                   mul_b = '0;              end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	assign ssum = 51'(sa_q) + 51'(acc_q[65:16]);
	assign snew = (ssum > 51'(PW_MAX)) ? PW_MAX : ssum[PW_W-1:0];
	assign nsat = (|acc_q[65:60]) ? PW_MAX : acc_q[59:12];
	assign use_floor = (pw_q == '0) || (nsat >= pw_q);
	assign gdiv = UNITY - {1'b0, quo};
	assign scl  = acc_q[39:16];

	always_comb begin
		sres = scl;
		if ((state_q == ST_SC1 && nre_q) || (state_q == ST_SC2 && nim_q)) begin
			sres = 24'd0 - scl;
		end
	end

	// memories
	assign sp_we    = (state_q == ST_CLR) || (state_q == ST_SM4);
	assign sp_waddr = (state_q == ST_CLR) ? clr_q : idx_q;
	assign sp_wdata = (state_q == ST_CLR) ? '0 : snew;
	assign hist_we  = (state_q == ST_SM4);

	msss_ram #(.DEPTH(BINS), .WIDTH(PW_W)) u_sp_ram (
		.clk   (clk),
		.we    (sp_we),
		.waddr (sp_waddr),
		.wdata (sp_wdata),
		.raddr (in_data.bin_index[IDX_W-1:0]),
		.rdata (sp_rdata)
	);

	msss_ram #(.DEPTH(HIST_DEPTH), .WIDTH(PW_W)) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr ({slot_q, idx_q}),
		.wdata (snew),
		.raddr ({j_q[SLOT_W-1:0], idx_q}),
		.rdata (hist_rdata)
	);

	assign dctl_in.start = (state_q == ST_NZ2) && !use_floor;
	assign dctl_in.done  = 1'b0;

	msss_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (dctl_in),
		.num     (nsat),
		.den     (pw_q),
		.ctl_out (dctl_out),
		.quo     (quo)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLR:  if (clr_q == IDX_W'(BINS - 1)) state_d = ST_IDLE;
			ST_IDLE: if (accept) state_d = ST_PW0;
			ST_PW0:  state_d = ST_PW1;
			ST_PW1:  state_d = ST_SM0;
			ST_SM0:  state_d = ST_SM1;
			ST_SM1:  state_d = ST_SM2;
			ST_SM2:  state_d = ST_SM3;
			ST_SM3:  state_d = ST_SM4;
			ST_SM4:  state_d = ST_MIN;
			ST_MIN:  if (!j_go && !pend_q) state_d = ST_NZ0;
			ST_NZ0:  state_d = ST_NZ1;
			ST_NZ1:  state_d = ST_NZ2;
			ST_NZ2:  state_d = use_floor ? ST_SC0 : ST_DIV;
			ST_DIV:  if (dctl_out.done) state_d = ST_SC0;
			ST_SC0:  state_d = ST_SC1;
			ST_SC1:  state_d = ST_SC2;
			ST_SC2:  state_d = ST_DONE;
			ST_DONE: if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			slot_q      <= '0;
			filled_q    <= '0;
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
			j_q         <= '0;
			alpha_q     <= ALPHA_RST;
			bias_q      <= BIAS_RST;
			floor_q     <= FLOOR_RST;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_we) begin
				case (cfg_addr)
					CFG_ALPHA: alpha_q <= cfg_wdata[15:0];
					CFG_BIAS:  bias_q  <= cfg_wdata[15:0];
					CFG_FLOOR: floor_q <= cfg_wdata;
					default:   ;
				endcase
			end
			if (state_q == ST_SM4) begin
				j_q    <= '0;
				pend_q <= 1'b0;
			end else if (state_q == ST_MIN) begin
				pend_q <= j_go;
				if (j_go) j_q <= j_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (last_q) begin
					slot_q <= (slot_q == SLOT_W'(WINDOW_FRAMES - 1)) ? '0 : slot_q + 1'b1;
					if (filled_q < FILL_W'(WINDOW_FRAMES)) filled_q <= filled_q + 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (accept) begin
				idx_q  <= in_data.bin_index[IDX_W-1:0];
				nre_q  <= in_data.bin_real[23];
				nim_q  <= in_data.bin_imag[23];
				mre_q  <= in_data.bin_real[23] ? 24'd0 - in_data.bin_real : in_data.bin_real;
				mim_q  <= in_data.bin_imag[23] ? 24'd0 - in_data.bin_imag : in_data.bin_imag;
				last_q <= in_data.frame_end;
			end
			ST_PW0: begin
				old_q <= sp_rdata;
				acc_q <= 66'(mul_p);
			end
			ST_PW1: pw_q  <= 48'(acc_q + 66'(mul_p));
			ST_SM0: acc_q <= 66'(mul_p);
			ST_SM1: acc_q <= acc_q + 66'({mul_p, 24'b0});
			ST_SM2: begin
				sa_q  <= acc_q[63:16];
				acc_q <= 66'(mul_p);
			end
			ST_SM3: acc_q <= acc_q + 66'({mul_p, 24'b0});
			ST_SM4: mn_q  <= PW_MAX;
			ST_MIN: if (pend_q && hist_rdata < mn_q) mn_q <= hist_rdata;
			ST_NZ0: acc_q <= 66'(mul_p);
			ST_NZ1: acc_q <= acc_q + 66'({mul_p, 24'b0});
			ST_NZ2: if (use_floor) gain_q <= floorv;
			ST_DIV: if (dctl_out.done) gain_q <= (gdiv < floorv) ? floorv : gdiv;
			ST_SC0: acc_q <= 66'(mul_p);
			ST_SC1: begin
				ore_q <= sres;
				acc_q <= 66'(mul_p);
			end
			ST_SC2: oim_q <= sres;
			// result register changes only when the previous beat is gone
			ST_DONE: if (out_load) begin
				out_q.out_real     <= ore_q;
				out_q.out_imag     <= oim_q;
				out_q.applied_gain <= gain_q;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_div_needed: assert property (@(posedge clk) disable iff (!arst_n)
		dctl_in.start |-> (pw_q != '0) && (nsat < pw_q))
		else $error("divider started without noise below power");
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (gain_q <= UNITY) && (gain_q >= floorv))
		else $error("gain outside floor and unity");
	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= FILL_W'(WINDOW_FRAMES)) else $error("fill count above window");
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> !accept) else $error("beat taken during clear");
`endif
endmodule
`default_nettype wire

// ----- design/msss_ram.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// msss_ram
// Simple dual port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module msss_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 48
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- design/msss_div.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// msss_div
// Restoring divider, one quotient bit per cycle: floor(num * 2^16 / den)
// for num < den.
// ---------------------------------------------------------------------------
module msss_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire msss_pkg::div_ctl_t        ctl_in,
	input  wire logic [msss_pkg::PW_W-1:0] num,
	input  wire logic [msss_pkg::PW_W-1:0] den,
	output msss_pkg::div_ctl_t             ctl_out,
	output logic [msss_pkg::QUO_W-1:0]     quo
);
	import msss_pkg::*;

	logic [PW_W:0]            rem_q;
	logic [PW_W-1:0]          den_q;
	logic [QUO_W-1:0]         quo_q;
	logic [$clog2(QUO_W):0]   cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic [PW_W:0]            rem2;
	logic [PW_W:0]            diff;
	logic                     ge;

	assign rem2 = {rem_q[PW_W-1:0], 1'b0};
	assign ge   = rem2 >= {1'b0, den_q};
	assign diff = rem2 - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl_in.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(QUO_W)+1)'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff : rem2;
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign ctl_out.start = busy_q;
	assign ctl_out.done  = done_q;
	assign quo           = quo_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_in.start |-> !busy_q) else $error("divider started while busy");
`endif
endmodule
`default_nettype wire
